/* design/stunbr_pkg.sv */
// ----------------------------------------------------------------------------
// stunbr_pkg
// Shared types and constants for the STUN binding response parser: header
// layout, attribute kinds, the XOR key and the result status codes.
// ----------------------------------------------------------------------------
package stunbr_pkg;

    // message and attribute codes
    localparam logic [15:0] TYPE_BINDING_SUCCESS = 16'h0101;
    localparam logic [15:0] KIND_MAPPED          = 16'h0001;
    localparam logic [15:0] KIND_XOR_MAPPED      = 16'h0020;

    // key used to un-XOR the XOR-MAPPED-ADDRESS value
    localparam logic [15:0] XOR_PORT = 16'h2112;
    localparam logic [31:0] XOR_IP   = 32'h2112A442;

    // fixed header size in bytes
    localparam logic [15:0] HEADER_BYTES = 16'd20;

    // family value when no address attribute was loaded
    localparam logic [7:0] FAMILY_DEFAULT = 8'h01;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_WRONG_TYPE = 2'd1,
        ST_TRUNCATED  = 2'd2,
        ST_IGNORED    = 2'd3
    } t_status;

    // one received byte with its end-of-datagram mark
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_byte_item;

    // one per-packet result
    typedef struct packed {
        t_status     status;
        logic        address_found;
        logic        used_xor;
        logic [7:0]  family;
        logic [15:0] mapped_port;
        logic [31:0] mapped_ip;
        logic [31:0] cookie;
    } t_result;

endpackage

/* design/stunbr_in_reg.sv */
// ----------------------------------------------------------------------------
// stunbr_in_reg
// Input register: captures one datagram byte per request and holds it until
// the parser consumes it.
// ----------------------------------------------------------------------------
module stunbr_in_reg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  stunbr_pkg::t_byte_item i_item,
    input  logic                   i_advance,
    output logic                   o_valid,
    output stunbr_pkg::t_byte_item o_item
);
    import stunbr_pkg::*;

    logic       r_valid;
    t_byte_item r_item;

    // free when empty or when the held byte moves on this cycle
    assign o_ready = !r_valid || i_advance;

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* design/stunbr_parser.sv */
// ----------------------------------------------------------------------------
// stunbr_parser
// Per-packet parse state. Each step consumes one byte: header fields, then
// the attribute TLV walk inside the declared length. Also forms the result
// that goes out on the last byte and resets or locks the state afterwards.
// ----------------------------------------------------------------------------
module stunbr_parser (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  stunbr_pkg::t_byte_item i_item,
    output stunbr_pkg::t_result    o_result
);
    import stunbr_pkg::*;

    // packet state
    logic [15:0] r_offset, n_offset;
    logic [15:0] r_type, n_type;
    logic [15:0] r_length, n_length;
    logic [16:0] r_end, n_end;
    logic [31:0] r_cookie, n_cookie;
    logic [15:0] r_attr_d, n_attr_d;
    logic [15:0] r_kind, n_kind;
    logic [15:0] r_size, n_size;
    logic [7:0]  r_family, n_family;
    logic [15:0] r_port, n_port;
    logic [31:0] r_ip, n_ip;
    logic        r_xor, n_xor;
    logic        r_seen, n_seen;
    logic        r_resolved;

    logic [7:0]  b;
    logic [7:0]  xb;
    logic [7:0]  mask;
    logic        take;
    logic        in_attr;
    logic [16:0] size_p7;
    logic [16:0] attr_end;
    logic [15:0] d;
    logic [15:0] kind_full;
    logic        is_addr;
    t_status     status;

    assign b = i_item.data_byte;

    // padded attribute extent: 4 header bytes plus value rounded up to 4
    assign size_p7  = {1'b0, r_size} + 17'd7;
    assign attr_end = {size_p7[16:2], 2'b00};

    // offset inside the current attribute, restarting at its padded end
    assign d = ({1'b0, r_attr_d} == attr_end) ? 16'd0 : r_attr_d;

    assign kind_full = {r_kind[15:8], b};
    assign is_addr   = (r_kind == KIND_MAPPED) || (r_kind == KIND_XOR_MAPPED);

    assign take    = !r_resolved && (r_offset != 16'hFFFF);
    assign in_attr = (r_offset >= HEADER_BYTES) && (r_type == TYPE_BINDING_SUCCESS)
                     && ({1'b0, r_offset} < r_end);

    // un-XOR key byte for the address value bytes
    always_comb begin
        mask = 8'h00;
        if (r_kind == KIND_XOR_MAPPED) begin
            unique case (d[3:0])
                4'd6:    mask = XOR_PORT[15:8];
                4'd7:    mask = XOR_PORT[7:0];
                4'd8:    mask = XOR_IP[31:24];
                4'd9:    mask = XOR_IP[23:16];
                4'd10:   mask = XOR_IP[15:8];
                4'd11:   mask = XOR_IP[7:0];
                default: mask = 8'h00;
            endcase
        end
    end
    assign xb = b ^ mask;

    // byte update
    always_comb begin
        n_offset = r_offset;
        n_type   = r_type;
        n_length = r_length;
        n_end    = r_end;
        n_cookie = r_cookie;
        n_attr_d = r_attr_d;
        n_kind   = r_kind;
        n_size   = r_size;
        n_family = r_family;
        n_port   = r_port;
        n_ip     = r_ip;
        n_xor    = r_xor;
        n_seen   = r_seen;
        if (take) begin
            n_offset = r_offset + 16'd1;
            priority if (r_offset == 16'd0) begin
                n_type = {b, 8'h00};
            end else if (r_offset == 16'd1) begin
                n_type = {r_type[15:8], b};
            end else if (r_offset == 16'd2) begin
                n_length = {b, 8'h00};
                n_end    = {1'b0, b, 8'h00} + {1'b0, HEADER_BYTES};
            end else if (r_offset == 16'd3) begin
                n_length = {r_length[15:8], b};
                n_end    = {1'b0, r_length[15:8], b} + {1'b0, HEADER_BYTES};
            end else if (r_offset[15:2] == 14'd1) begin
                // cookie bytes, first in the high bits
                unique case (r_offset[1:0])
                    2'd0: n_cookie[31:24] = b;
                    2'd1: n_cookie[23:16] = b;
                    2'd2: n_cookie[15:8]  = b;
                    2'd3: n_cookie[7:0]   = b;
                    default: n_cookie = r_cookie;
                endcase
            end else if (in_attr) begin
                n_attr_d = d + 16'd1;
                if (d[15:2] == 14'd0) begin
                    // attribute type and length
                    unique case (d[1:0])
                        2'd0: n_kind = {b, 8'h00};
                        2'd1: begin
                            n_kind = kind_full;
                            if (kind_full == KIND_MAPPED || kind_full == KIND_XOR_MAPPED) begin
                                n_seen = 1'b1;
                                n_xor  = (kind_full == KIND_XOR_MAPPED);
                            end
                        end
                        2'd2: n_size = {b, 8'h00};
                        2'd3: n_size = {r_size[15:8], b};
                        default: n_kind = r_kind;
                    endcase
                end else if (is_addr && d[15:4] == 12'd0) begin
                    // address value bytes
                    unique case (d[3:0])
                        4'd5:    n_family      = xb;
                        4'd6:    n_port[15:8]  = xb;
                        4'd7:    n_port[7:0]   = xb;
                        4'd8:    n_ip[31:24]   = xb;
                        4'd9:    n_ip[23:16]   = xb;
                        4'd10:   n_ip[15:8]    = xb;
                        4'd11:   n_ip[7:0]     = xb;
                        default: n_family      = r_family;
                    endcase
                end
            end else begin
                // transaction id and bytes outside the body are skipped
            end
        end
    end

    // status as seen after this byte
    always_comb begin
        priority if (r_resolved) begin
            status = ST_IGNORED;
        end else if (n_offset < 16'd2) begin
            status = ST_TRUNCATED;
        end else if (n_type != TYPE_BINDING_SUCCESS) begin
            status = ST_WRONG_TYPE;
        end else if ({1'b0, n_offset} < n_end) begin
            status = ST_TRUNCATED;
        end else begin
            status = ST_OK;
        end
    end

    assign o_result.status        = status;
    assign o_result.address_found = n_seen;
    assign o_result.used_xor      = n_xor;
    assign o_result.family        = n_family;
    assign o_result.mapped_port   = n_port;
    assign o_result.mapped_ip     = n_ip;
    assign o_result.cookie        = n_cookie;

    // state registers; a failed packet returns everything to reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte
                         && (status == ST_WRONG_TYPE || status == ST_TRUNCATED))) begin
            r_offset <= '0;
            r_type   <= '0;
            r_length <= '0;
            r_end    <= {1'b0, HEADER_BYTES};
            r_cookie <= '0;
            r_attr_d <= '0;
            r_kind   <= '0;
            r_size   <= '0;
            r_family <= FAMILY_DEFAULT;
            r_port   <= '0;
            r_ip     <= '0;
            r_xor    <= 1'b0;
            r_seen   <= 1'b0;
        end else if (i_step) begin
            r_offset <= n_offset;
            r_type   <= n_type;
            r_length <= n_length;
            r_end    <= n_end;
            r_cookie <= n_cookie;
            r_attr_d <= n_attr_d;
            r_kind   <= n_kind;
            r_size   <= n_size;
            r_family <= n_family;
            r_port   <= n_port;
            r_ip     <= n_ip;
            r_xor    <= n_xor;
            r_seen   <= n_seen;
        end
    end

    // lock after the first good packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resolved <= 1'b0;
        end else if (i_step && i_item.last_byte && status == ST_OK) begin
            r_resolved <= 1'b1;
        end
    end

endmodule

/* design/stunbr_out_reg.sv */
// ----------------------------------------------------------------------------
// stunbr_out_reg
// Result register: holds one packet result until the downstream side takes
// it, and reloads in the same cycle the old one leaves.
// ----------------------------------------------------------------------------
module stunbr_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  stunbr_pkg::t_result i_result,
    input  logic                i_ready,
    output logic                o_free,
    output logic                o_valid,
    output stunbr_pkg::t_result o_result
);
    import stunbr_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // result capture
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* design/stun_binding_response_parser.sv */
// ----------------------------------------------------------------------------
// stun_binding_response_parser
// Parses a STUN binding success response fed one byte per request and
// reports the mapped IPv4 transport address and a status once per datagram.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_data_byte, i_last_byte
//  out     | output    | o_out_valid / i_out_ready  | o_status, o_address_found,
//          |           |                            | o_used_xor, o_family,
//          |           |                            | o_mapped_port, o_mapped_ip,
//          |           |                            | o_cookie
//
//  one byte per cycle unless a last byte waits on a full result register: input register, parse logic, result register
//  a result is loaded into the result register when its last byte leaves the input register
//  only a last byte waits on a full result register; other bytes always move
//  synchronous active-low reset clears the parse state and empties both stages
// ----------------------------------------------------------------------------
module stun_binding_response_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_address_found,
    output logic        o_used_xor,
    output logic [7:0]  o_family,
    output logic [15:0] o_mapped_port,
    output logic [31:0] o_mapped_ip,
    output logic [31:0] o_cookie
);
    import stunbr_pkg::*;

    t_byte_item in_item;
    t_byte_item held_item;
    logic       held_valid;
    logic       out_free;
    logic       advance;
    t_result    parse_result;
    t_result    out_result;

    assign in_item.data_byte = i_data_byte;
    assign in_item.last_byte = i_last_byte;

    // a held byte moves on unless it ends a packet and the result slot is busy
    assign advance = held_valid && (!held_item.last_byte || out_free);

    // input stage
    stunbr_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    // parse state and result forming
    stunbr_parser u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (held_item),
        .o_result (parse_result)
    );

    // result stage
    stunbr_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && held_item.last_byte),
        .i_result (parse_result),
        .i_ready  (i_out_ready),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_status        = out_result.status;
    assign o_address_found = out_result.address_found;
    assign o_used_xor      = out_result.used_xor;
    assign o_family        = out_result.family;
    assign o_mapped_port   = out_result.mapped_port;
    assign o_mapped_ip     = out_result.mapped_ip;
    assign o_cookie        = out_result.cookie;

endmodule

/* design/stunbr_checker.sv */
// ----------------------------------------------------------------------------
// stunbr_checker
// Port-level checks for the STUN binding response parser: result hold under
// stall, lock after the first good packet, and defaults without an address.
// ----------------------------------------------------------------------------
module stunbr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  o_status,
    input  logic        o_address_found,
    input  logic        o_used_xor,
    input  logic [7:0]  o_family,
    input  logic [15:0] o_mapped_port,
    input  logic [31:0] o_mapped_ip,
    input  logic [31:0] o_cookie
);
    import stunbr_pkg::*;

    logic r_seen_ok;

    // remember that a good packet result was delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_ok <= 1'b0;
        end else if (o_out_valid && i_out_ready && o_status == ST_OK) begin
            r_seen_ok <= 1'b1;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_mapped_ip)
            && $stable(o_mapped_port) && $stable(o_cookie))
        else $error("result changed while stalled");

    // after a good packet every result reports ignored
    a_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_ok |-> o_status == ST_IGNORED)
        else $error("result after lock not ignored");

    // ignored only once a good packet went out
    a_ignored_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_IGNORED |-> r_seen_ok)
        else $error("ignored reported before any good packet");

    // without an address attribute the address fields keep their defaults
    a_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_address_found |->
            !o_used_xor && o_family == FAMILY_DEFAULT
            && o_mapped_port == 16'd0 && o_mapped_ip == 32'd0)
        else $error("address fields set without an address attribute");

endmodule

bind stun_binding_response_parser stunbr_checker u_stunbr_checker (.*);

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stun_binding_response_parser. Byte requests are
// built into whole datagrams: short and broken headers, foreign types, and
// responses cut short of their declared length. Then one response that
// parses and datagrams sent after it. A predictor follows every accepted
// byte, and each result is compared field by field in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stunbr_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 3;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 8;
    localparam int PHASE_BYTES  = 70;
    localparam int PHASE_DGRAMS = 3;
    localparam int MAX_REPORTS  = 40;

    // how the declared body length relates to the attributes that follow
    typedef enum {LEN_EXACT, LEN_OVER, LEN_UNDER, LEN_MAX} t_len_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic        o_address_found;
    logic        o_used_xor;
    logic [7:0]  o_family;
    logic [15:0] o_mapped_port;
    logic [31:0] o_mapped_ip;
    logic [31:0] o_cookie;

    // predicted parser state
    logic [15:0] rx_offset;
    logic [15:0] rx_type;
    logic [15:0] rx_length;
    logic [31:0] rx_cookie;
    logic [15:0] tlv_base;
    logic [15:0] tlv_kind;
    logic [15:0] tlv_len;
    logic [7:0]  addr_family;
    logic [15:0] addr_port;
    logic [31:0] addr_ip;
    logic        addr_xor;
    logic        addr_seen;
    logic        binding_done;

    t_result     pending_bindings[$];

    // datagram under construction
    logic [7:0]  tlv_bytes[$];
    logic [7:0]  dgram[$];
    logic [15:0] declared_len;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          sender_calm = 0;
    int          receiver_calm = 0;
    int unsigned bytes_accepted = 0;
    int unsigned datagrams_accepted = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatch_count = 0;

    stun_binding_response_parser DUT (.*);

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic void restart_datagram();
        rx_offset   = '0;
        rx_type     = '0;
        rx_length   = '0;
        rx_cookie   = '0;
        tlv_base    = '0;
        tlv_kind    = '0;
        tlv_len     = '0;
        addr_family = FAMILY_DEFAULT;
        addr_port   = '0;
        addr_ip     = '0;
        addr_xor    = 1'b0;
        addr_seen   = 1'b0;
    endfunction

    // one body byte, rel counted from the end of the header
    function automatic void walk_attribute(input int unsigned rel, input logic [7:0] b);
        int unsigned padded;
        int unsigned d;
        int          sh;
        logic [7:0]  v;
        padded = (32'(tlv_len) + 3) & 32'hFFFF_FFFC;
        d      = rel - 32'(tlv_base);
        v      = b;
        // next tlv starts once the padded value is used up
        if (d >= 4 && d == 4 + padded) begin
            tlv_base = 16'(rel);
            d = 0;
        end
        if (d == 0) begin
            tlv_kind = {b, 8'h00};
        end else if (d == 1) begin
            tlv_kind[7:0] = b;
            if (tlv_kind == KIND_MAPPED || tlv_kind == KIND_XOR_MAPPED) begin
                addr_seen = 1'b1;
                addr_xor  = (tlv_kind == KIND_XOR_MAPPED);
            end
        end else if (d == 2) begin
            tlv_len = {b, 8'h00};
        end else if (d == 3) begin
            tlv_len[7:0] = b;
        end else if (d < 4 + padded &&
                     (tlv_kind == KIND_MAPPED || tlv_kind == KIND_XOR_MAPPED)) begin
            // un-xor port and address with the fixed XOR key
            if (tlv_kind == KIND_XOR_MAPPED) begin
                if (d == 6)
                    v = v ^ XOR_PORT[15:8];
                else if (d == 7)
                    v = v ^ XOR_PORT[7:0];
                else if (d >= 8 && d <= 11)
                    v = v ^ XOR_IP[8 * (11 - int'(d)) +: 8];
            end
            if (d == 5) begin
                addr_family = v;
            end else if (d == 6) begin
                addr_port[15:8] = v;
            end else if (d == 7) begin
                addr_port[7:0] = v;
            end else if (d >= 8 && d <= 11) begin
                sh = 8 * (11 - int'(d));
                addr_ip[sh +: 8] = v;
            end
        end
    endfunction

    function automatic void take_byte(input logic [15:0] pos, input logic [7:0] b);
        int sh;
        if (pos == 0) begin
            rx_type = {b, 8'h00};
        end else if (pos == 1) begin
            rx_type[7:0] = b;
        end else if (pos == 2) begin
            rx_length = {b, 8'h00};
        end else if (pos == 3) begin
            rx_length[7:0] = b;
        end else if (pos >= 4 && pos <= 7) begin
            sh = 8 * (7 - int'(pos));
            rx_cookie[sh +: 8] = b;
        end else if (pos >= HEADER_BYTES && rx_type == TYPE_BINDING_SUCCESS) begin
            // only bytes inside the declared body are walked
            if (32'(pos) - 32'(HEADER_BYTES) < 32'(rx_length))
                walk_attribute(32'(pos) - 32'(HEADER_BYTES), b);
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic is_last);
        t_result     r;
        t_status     st;
        int unsigned received;
        // offset saturates, later bytes are dropped
        if (!binding_done && rx_offset != 16'hFFFF) begin
            take_byte(rx_offset, b);
            rx_offset++;
        end
        if (!is_last)
            return;
        received = rx_offset;
        if (binding_done)
            st = ST_IGNORED;
        else if (received < 2)
            st = ST_TRUNCATED;
        else if (rx_type != TYPE_BINDING_SUCCESS)
            st = ST_WRONG_TYPE;
        else if (received < 32'(HEADER_BYTES) + 32'(rx_length))
            st = ST_TRUNCATED;
        else
            st = ST_OK;
        r.status        = st;
        r.address_found = addr_seen;
        r.used_xor      = addr_xor;
        r.family        = addr_family;
        r.mapped_port   = addr_port;
        r.mapped_ip     = addr_ip;
        r.cookie        = rx_cookie;
        pending_bindings.push_back(r);
        if (st == ST_OK)
            binding_done = 1'b1;
        else if (st != ST_IGNORED)
            restart_datagram();
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_binding();
        t_result want;
        if (pending_bindings.size() == 0) begin
            report_mismatch("result with no datagram pending");
            return;
        end
        want = pending_bindings.pop_front();
        if (o_status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", o_status, want.status));
        if (o_address_found !== want.address_found)
            report_mismatch($sformatf("address_found got %0b want %0b",
                                      o_address_found, want.address_found));
        if (o_used_xor !== want.used_xor)
            report_mismatch($sformatf("used_xor got %0b want %0b", o_used_xor, want.used_xor));
        if (o_family !== want.family)
            report_mismatch($sformatf("family got %h want %h", o_family, want.family));
        if (o_mapped_port !== want.mapped_port)
            report_mismatch($sformatf("mapped_port got %h want %h",
                                      o_mapped_port, want.mapped_port));
        if (o_mapped_ip !== want.mapped_ip)
            report_mismatch($sformatf("mapped_ip got %h want %h", o_mapped_ip, want.mapped_ip));
        if (o_cookie !== want.cookie)
            report_mismatch($sformatf("cookie got %h want %h", o_cookie, want.cookie));
    endtask

    // result monitor and stall counter
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n && o_out_valid && i_out_ready)
            check_binding();
    end

    // watchdog
    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("[%0t] watchdog: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // result side back-pressure, with calm stretches
    always @(posedge i_clk) begin
        if (receiver_calm > 0) begin
            i_out_ready   <= 1'b1;
            receiver_calm <= receiver_calm - 1;
        end else if ($urandom_range(0, 63) == 0) begin
            i_out_ready   <= 1'b1;
            receiver_calm <= $urandom_range(16, 48);
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // one byte request, predicted once accepted
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while (sender_calm == 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        if (sender_calm > 0)
            sender_calm--;
        else if ($urandom_range(0, 63) == 0)
            sender_calm = $urandom_range(16, 48);
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= is_last;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        parse_byte(b, is_last);
        bytes_accepted++;
        if (is_last)
            datagrams_accepted++;
    endtask

    // sends n bytes of the datagram, padding with random bytes past its end
    task automatic send_datagram(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            send_byte((i < dgram.size()) ? dgram[i] : 8'($urandom), i == n - 1);
    endtask

    task automatic add_attribute(input logic [15:0] kind, input logic [15:0] size,
                                 input bit addr_like);
        logic [63:0] addr_val;
        int unsigned padded;
        padded   = (32'(size) + 3) & 32'hFFFF_FFFC;
        addr_val = {8'h00,
                    ($urandom_range(0, 3) == 0) ? 8'($urandom) : FAMILY_DEFAULT,
                    16'($urandom), 32'($urandom)};
        tlv_bytes.push_back(kind[15:8]);
        tlv_bytes.push_back(kind[7:0]);
        tlv_bytes.push_back(size[15:8]);
        tlv_bytes.push_back(size[7:0]);
        for (int i = 0; i < padded; i++)
            tlv_bytes.push_back((addr_like && i < 8) ? addr_val[63 - 8 * i -: 8]
                                                     : 8'($urandom));
    endtask

    task automatic make_attributes(input int max_count);
        int          attr_count;
        logic [15:0] other;
        tlv_bytes.delete();
        attr_count = $urandom_range(0, max_count);
        repeat (attr_count) begin
            case ($urandom_range(0, 9))
                0, 1, 2: add_attribute(KIND_MAPPED, 16'd8, 1'b1);
                3, 4, 5: add_attribute(KIND_XOR_MAPPED, 16'd8, 1'b1);
                // short or oversized address value
                6: add_attribute($urandom_range(0, 1) ? KIND_MAPPED : KIND_XOR_MAPPED,
                                 16'($urandom_range(0, 12)), 1'b1);
                7: add_attribute(KIND_XOR_MAPPED, 16'd20, 1'b1);
                default: begin
                    // unknown kinds, some one bit away from an address kind
                    other = $urandom_range(0, 1) ? 16'($urandom)
                          : (($urandom_range(0, 1) ? KIND_MAPPED : KIND_XOR_MAPPED)
                             ^ (16'd1 << $urandom_range(0, 15)));
                    add_attribute(other, 16'($urandom_range(0, 16)), 1'b0);
                end
            endcase
        end
    endtask

    // header plus the attributes in tlv_bytes
    task automatic make_datagram(input logic [15:0] msg_type, input t_len_mode len_mode);
        logic [31:0] magic;
        int unsigned span;
        span = tlv_bytes.size();
        case (len_mode)
            LEN_EXACT: declared_len = 16'(span);
            LEN_OVER:  declared_len = 16'(span + $urandom_range(1, 8));
            LEN_UNDER: declared_len = 16'($urandom_range(0, span));
            default:   declared_len = 16'hFFFF;
        endcase
        magic = ($urandom_range(0, 7) == 0) ? $urandom : XOR_IP;
        dgram = '{msg_type[15:8], msg_type[7:0], declared_len[15:8], declared_len[7:0],
                  magic[31:24], magic[23:16], magic[15:8], magic[7:0]};
        // transaction id
        repeat (12) dgram.push_back(8'($urandom));
        dgram = {dgram, tlv_bytes};
    endtask

    // a datagram that cannot parse: noise, foreign type or cut short
    task automatic send_failing_datagram();
        logic [15:0] msg_type;
        int unsigned n;
        int unsigned limit;
        t_len_mode   mode;
        mode = t_len_mode'($urandom_range(0, 2));
        case ($urandom_range(0, 9))
            0, 1: begin
                n = $urandom_range(1, 12);
                dgram.delete();
                repeat (n) dgram.push_back(8'($urandom));
                if (n >= 2 && {dgram[0], dgram[1]} == TYPE_BINDING_SUCCESS)
                    dgram[1] = ~dgram[1];
            end
            2, 3: begin
                make_attributes(3);
                msg_type = 16'($urandom);
                if (msg_type == TYPE_BINDING_SUCCESS)
                    msg_type = ~msg_type;
                make_datagram(msg_type, mode);
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, dgram.size())
                                                : dgram.size() + $urandom_range(0, 2);
            end
            default: begin
                // well formed response that ends before its declared length
                make_attributes(4);
                make_datagram(TYPE_BINDING_SUCCESS, mode);
                limit = 32'(HEADER_BYTES) + 32'(declared_len) - 1;
                if (mode == LEN_OVER)
                    n = dgram.size();
                else if ($urandom_range(0, 4) == 0)
                    n = $urandom_range(1, HEADER_BYTES - 1);
                else
                    n = limit - $urandom_range(0, 6);
            end
        endcase
        send_datagram(n);
    endtask

    task automatic run_failing_phase();
        int unsigned first_byte;
        int unsigned first_dgram;
        first_byte  = bytes_accepted;
        first_dgram = datagrams_accepted;
        while (bytes_accepted - first_byte < PHASE_BYTES ||
               datagrams_accepted - first_dgram < PHASE_DGRAMS)
            send_failing_datagram();
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_short_datagrams();
        send_idle_pct = 37;
        recv_idle_pct = 72;
        // single byte, too short to hold a type
        dgram = '{8'hFF};
        send_datagram(1);
        dgram = '{8'h00};
        send_datagram(1);
        // foreign type
        dgram = '{8'h00, 8'h00};
        send_datagram(2);
        // success type, header stops early
        dgram = '{TYPE_BINDING_SUCCESS[15:8], TYPE_BINDING_SUCCESS[7:0]};
        send_datagram(2);
        dgram = '{TYPE_BINDING_SUCCESS[15:8], TYPE_BINDING_SUCCESS[7:0], 8'hFF};
        send_datagram(3);
        // foreign type with a partial cookie
        dgram = '{TYPE_BINDING_SUCCESS[15:8], 8'hFF, 8'hFF, 8'hFF,
                  XOR_IP[31:24], XOR_IP[23:16], XOR_IP[15:8]};
        send_datagram(7);
    endtask

    task automatic test_stalled_receiver();
        send_idle_pct = 37;
        recv_idle_pct = 72;
        run_failing_phase();
    endtask

    // sender holds off until every result is back
    task automatic test_drain_pause();
        repeat (2) send_failing_datagram();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_bindings.size() != 0);
        repeat (2) send_failing_datagram();
    endtask

    task automatic test_stalled_sender();
        send_idle_pct = 72;
        recv_idle_pct = 37;
        run_failing_phase();
    endtask

    task automatic test_back_to_back();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_failing_phase();
    endtask

    task automatic test_resolve_then_ignore();
        make_attributes(3);
        add_attribute(KIND_XOR_MAPPED, 16'd8, 1'b1);
        add_attribute(KIND_MAPPED, 16'($urandom_range(4, 8)), 1'b1);
        make_datagram(TYPE_BINDING_SUCCESS, $urandom_range(0, 1) ? LEN_EXACT : LEN_UNDER);
        // trailing bytes past the declared end
        send_datagram(dgram.size() + $urandom_range(1, 6));
        // everything after a good parse is ignored
        repeat (3) send_failing_datagram();
        make_attributes(2);
        make_datagram(TYPE_BINDING_SUCCESS, LEN_EXACT);
        send_datagram(dgram.size());
    endtask

    // main sequence
    initial begin
        int unsigned waited;
        restart_datagram();
        binding_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_datagrams();
        test_stalled_receiver();
        test_drain_pause();
        test_stalled_sender();
        test_back_to_back();
        test_resolve_then_ignore();

        // drain outstanding results
        i_in_valid <= 1'b0;
        waited = 0;
        while (pending_bindings.size() != 0 && waited < STALL_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_bindings.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_bindings.size()));

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
